/* rtl/dde_pkg.sv */
`default_nettype none
package dde_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_SEARCH     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DUP   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned IN_TDATA_BITS = 32;
  localparam int unsigned OUT_TDATA_BITS = 40;

  typedef struct packed {
    logic shift;
    logic append;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/dedup_deque_engine_unit.sv */
`default_nettype none
// Bounded deque of up to CAPACITY values held in a row of cells, the front in
// cell 0. Each transaction carries an operation in s_tuser and a value in
// s_tdata and gives exactly one result: status in m_tuser, the popped value
// and the search flag in m_tdata. The per-cell comparators test all entries
// at once and the row shifts or fills in parallel, so the block takes one
// transaction per cycle while the output register is not stalled. The result
// is registered and shows in the cycle after acceptance; s_tready is high while
// the output register is empty or being taken. Push back skips duplicates and
// checks for a duplicate before fullness.
module dedup_deque_engine_unit #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [dde_pkg::IN_TDATA_BITS-1:0]    s_tdata,  // value[31:0]
  input  wire logic [1:0]                           s_tuser,  // operation[1:0]
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic      [dde_pkg::OUT_TDATA_BITS-1:0]   m_tdata,  // popped_value[31:0], found[32]
  output logic      [1:0]                           m_tuser   // status[1:0]
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  found_any;
  logic [VALUE_BITS-1:0] key;
  logic [VALUE_BITS-1:0] back_data;
  dde_pkg::op_t          op;
  dde_pkg::status_t      status_next;
  dde_pkg::status_t      status;
  dde_pkg::cell_ctl_t    ctl;
  logic [31:0]           popped_next;
  logic [31:0]           popped;
  logic                  found_next;
  logic                  found;

  logic [VALUE_BITS-1:0] cell_data [CAPACITY];
  logic [VALUE_BITS-1:0] cell_back [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;
  logic [CAPACITY-1:0]   cell_last;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = dde_pkg::op_t'(s_tuser);
  assign key      = VALUE_BITS'(s_tdata[dde_pkg::FIELD_BITS-1:0]);
  assign full     = count == CNT_FULL;
  assign empty    = count == '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dde_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .key       (key),
      .prev_data ((i == 0) ? key : cell_data[(i == 0) ? 0 : i - 1]),
      .data      (cell_data[i]),
      .match     (cell_match[i]),
      .last      (cell_last[i])
    );
    assign cell_back[i] = cell_last[i] ? cell_data[i] : '0;
  end

  assign found_any = |cell_match;

  always_comb begin
    back_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_data = back_data | cell_back[i];
    end
  end

  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = dde_pkg::ST_OK;
    popped_next = '0;
    found_next  = 1'b0;
    case (op)
      dde_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_next = dde_pkg::ST_FULL;
        end else begin
          ctl.shift  = 1'b1;
          count_next = count + CNT_ONE;
        end
      end
      dde_pkg::OP_PUSH_BACK: begin
        if (found_any) begin
          status_next = dde_pkg::ST_DUP;
        end else if (full) begin
          status_next = dde_pkg::ST_FULL;
        end else begin
          ctl.append = 1'b1;
          count_next = count + CNT_ONE;
        end
      end
      dde_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_next = dde_pkg::ST_EMPTY;
        end else begin
          popped_next = 32'(back_data);
          count_next  = count - CNT_ONE;
        end
      end
      dde_pkg::OP_SEARCH: begin
        found_next = found_any;
      end
      default: begin
        status_next = dde_pkg::ST_OK;
      end
    endcase
    if (!accept) begin
      ctl        = '0;
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      popped <= popped_next;
      found  <= found_next;
    end
  end

  assign m_tdata = {7'd0, found, popped};
  assign m_tuser = status;

endmodule
`default_nettype wire

/* rtl/dde_cell.sv */
`default_nettype none
module dde_cell #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire dde_pkg::cell_ctl_t    ctl,
  input  wire logic [CNT_W-1:0]      count,
  input  wire logic [VALUE_BITS-1:0] key,
  input  wire logic [VALUE_BITS-1:0] prev_data,
  output logic      [VALUE_BITS-1:0] data,
  output logic                       match,
  output logic                       last
);

  localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);

  logic occupied;

  assign occupied = count > IDX;
  assign match    = occupied && (data == key);
  assign last     = count == IDX1;

  // front side shifts toward the back, append lands on the first free cell
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= prev_data;
    end else if (ctl.append && (count == IDX)) begin
      data <= key;
    end
  end

endmodule
`default_nettype wire

/* rtl/dde_checker.sv */
`default_nettype none
module dde_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [31:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // no result waits right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // every accepted transaction gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted transaction gave no result");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // found and a popped value only come with ok status, never together
  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[32] || (m_tdata[31:0] != 32'd0))) |->
      ((m_tuser == dde_pkg::ST_OK) && !(m_tdata[32] && (m_tdata[31:0] != 32'd0))))
    else $error("inconsistent result fields");

  // input side is never blocked while the output register is empty
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("not ready with empty output register");

endmodule

bind dedup_deque_engine_unit dde_checker u_dde_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
